FILE: hw/rtl/prda_pkg.sv
// prda_pkg: shared types, constants and helpers for the report delta accumulator
// depends on nothing; imported by prda_div, the top level and prda_checker

package prda_pkg;

    localparam int IN_W   = 72;   // start_word, end_word, word_index, clear_before
    localparam int OUT_W  = 208;  // 201 payload bits, padded to bytes
    localparam int NSUMS  = 62;
    localparam int QW     = 62;   // scaled time quotient width

    localparam logic [5:0]  LAST_WORD      = 6'd63;
    localparam logic [5:0]  LAST_SUM       = 6'd61;
    localparam logic [31:0] SWITCH_AWAY    = 32'h0001_ffff;
    localparam logic [29:0] NS_PER_SEC     = 30'd1000000000;
    localparam logic [29:0] HZ_RESET       = 30'd12500000;
    localparam logic [5:0]  HIGH_BYTE_BASE = 6'd40;

    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_PCM    = 2'd1;
    localparam logic [1:0] REG_HZ     = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_MUL,
        ST_DIV,
        ST_DIVW,
        ST_CHECK,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } state_t;

    typedef enum logic [1:0] {
        PH_INIT,
        PH_T1,
        PH_T2
    } phase_t;

    typedef struct packed {
        logic          start;
        logic [QW-1:0] dividend;
        logic [29:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic          done;
        logic [QW-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic       touched;
        logic       wide;
        logic [5:0] lo;
        logic [5:0] hi;
        logic [1:0] bsel;
    } src_t;

    // report word locations that feed accumulator n
    function automatic src_t sum_source(input logic fmt, input logic [5:0] n);
        src_t       s;
        logic [5:0] k;
        k = n - 6'd2;
        s.touched = 1'b1;
        s.wide    = 1'b0;
        s.lo      = n + 6'd2;
        s.hi      = HIGH_BYTE_BASE + {2'b00, k[5:2]};
        s.bsel    = k[1:0];
        if (n == 6'd0)
        begin
            s.lo = 6'd1;
        end
        else if (fmt)
        begin
            s.lo = n + 6'd2;
        end
        else if (n == 6'd1)
        begin
            s.lo = 6'd3;
        end
        else if (n <= 6'd33)
        begin
            s.wide = 1'b1;
        end
        else if (n <= 6'd37)
        begin
            s.lo = n + 6'd2;
        end
        else if (n <= 6'd53)
        begin
            s.lo = n + 6'd10;
        end
        else
        begin
            s.touched = 1'b0;
        end
        return s;
    endfunction

endpackage

FILE: hw/rtl/prda_div.sv
// prda_div: restoring divider, one quotient bit per cycle
// depends on prda_pkg

module prda_div (
    input  logic               clk,
    input  logic               rst_n,
    input  prda_pkg::div_req_t req,
    output prda_pkg::div_rsp_t rsp
);
    import prda_pkg::*;

    logic [QW-1:0] sh_reg, sh_next;
    logic [30:0]   rem_reg, rem_next;
    logic [29:0]   dvs_reg, dvs_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [30:0]   trial;

    always_comb
    begin
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[29:0], sh_reg[QW-1]};
        if (req.start)
        begin
            sh_next   = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                sh_next  = {sh_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                sh_next  = {sh_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(QW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = sh_reg;

endmodule

FILE: hw/rtl/prda_mem.sv
// prda_mem: 64 x 32 report word store, one write port, two registered read ports
// depends on nothing

module prda_mem (
    input  logic        clk,
    input  logic        we,
    input  logic [5:0]  waddr,
    input  logic [31:0] wdata,
    input  logic [5:0]  raddr_a,
    input  logic [5:0]  raddr_b,
    output logic [31:0] rdata_a,
    output logic [31:0] rdata_b
);
    logic [31:0] mem [64];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: hw/rtl/perf_report_delta_accumulator.sv
// perf_report_delta_accumulator: top level, sequencer, clock extension, accumulators
// depends on prda_pkg, prda_div, prda_mem
//
// channel   dir  handshake              contents
// s_axis    in   tvalid/tready          start_word, end_word, word_index, clear_before
// m_axis    out  tvalid/tready, tlast   one accumulator word per index, tlast on index 61
// cfg       in   cfg_valid/cfg_ready    cfg_index, cfg_data (always ready)
//
// a word with index below 63 is taken without leaving idle
// word 63 runs zero to three time scalings through the bit-serial divider, then the
// accumulator pass if the check passes, then EMIT_RD, EMIT_LD and EMIT_WAIT per result
// s_axis_tready is low from word 63 until the last result is taken
// reset clears all control state, the clock and the accumulator valid bits

module perf_report_delta_accumulator (
    input  logic                       clk,
    input  logic                       rst_n,
    // start_word[31:0], end_word[63:32], word_index[69:64], clear_before[70]
    input  logic [prda_pkg::IN_W-1:0]  s_axis_tdata,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // delta_index[5:0], delta_value[69:6], accepted[70], switch_to_seen[71],
    // switch_from_seen[72], first_time_ns[136:73], last_time_ns[200:137]
    output logic [prda_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic                       m_axis_tlast,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [29:0]                cfg_data
);
    import prda_pkg::*;

    // input word fields
    logic [31:0] in_start, in_end;
    logic [5:0]  in_idx;
    logic        in_clear, in_acc;
    assign in_start = s_axis_tdata[31:0];
    assign in_end   = s_axis_tdata[63:32];
    assign in_idx   = s_axis_tdata[69:64];
    assign in_clear = s_axis_tdata[70];
    assign in_acc   = s_axis_tvalid && s_axis_tready;

    // config registers
    logic        fmt_reg, pcm_reg;
    logic [29:0] hz_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= 1'b0;
            pcm_reg <= 1'b0;
            hz_reg  <= HZ_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FORMAT: fmt_reg <= cfg_data[0];
                REG_PCM:    pcm_reg <= cfg_data[0];
                REG_HZ:     hz_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    // sequencer state
    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [5:0]  n_reg, n_next;
    logic        ok_reg, ok_next;
    logic        to_reg, to_next;
    logic        from_reg, from_next;
    logic        started_reg, started_next;
    logic [63:0] clock_reg, clock_next;
    logic [31:0] raw_reg, raw_next;
    logic [31:0] ctx_reg, ctx_next;
    logic [63:0] first_reg, first_next;
    logic [63:0] last_reg, last_next;
    logic [31:0] mul_a_reg, mul_a_next;
    logic [QW-1:0] prod_reg;

    // mirrors of timestamp and context words
    logic [31:0] s1_reg, e1_reg, s2_reg, e2_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc && in_idx == 6'd1)
        begin
            s1_reg <= in_start;
            e1_reg <= in_end;
        end
        if (in_acc && in_idx == 6'd2)
        begin
            s2_reg <= in_start;
            e2_reg <= in_end;
        end
    end

    // report stores
    src_t        src;
    logic [31:0] sl_q, sh_q, el_q, eh_q;
    assign src = sum_source(fmt_reg, n_reg);

    prda_mem u_start_mem (
        .clk     (clk),
        .we      (in_acc),
        .waddr   (in_idx),
        .wdata   (in_start),
        .raddr_a (src.lo),
        .raddr_b (src.hi),
        .rdata_a (sl_q),
        .rdata_b (sh_q)
    );

    prda_mem u_end_mem (
        .clk     (clk),
        .we      (in_acc),
        .waddr   (in_idx),
        .wdata   (in_end),
        .raddr_a (src.lo),
        .raddr_b (src.hi),
        .rdata_a (el_q),
        .rdata_b (eh_q)
    );

    // shared scaling unit: multiply stage then serial divide
    div_req_t dreq;
    div_rsp_t drsp;
    logic [63:0] q64;
    assign dreq.start    = (state_reg == ST_DIV);
    assign dreq.dividend = prod_reg;
    assign dreq.divisor  = (hz_reg == 30'd0) ? 30'd1 : hz_reg;
    assign q64           = {{(64 - QW){1'b0}}, drsp.quotient};

    prda_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_ff @(posedge clk)
    begin
        prod_reg <= QW'(mul_a_reg) * QW'(NS_PER_SEC);
    end

    // accumulator store with valid bits, invalid reads as zero
    logic [63:0]      acc_mem [NSUMS];
    logic [63:0]      acc_q;
    logic [NSUMS-1:0] acc_vld_reg;
    logic [63:0]      acc_cur, delta, acc_wdata;
    logic             acc_we;
    logic [7:0]       sbyte, ebyte;

    assign acc_cur = acc_vld_reg[n_reg] ? acc_q : 64'd0;

    always_comb
    begin
        sbyte = sh_q[8*src.bsel +: 8];
        ebyte = eh_q[8*src.bsel +: 8];
        if (src.wide)
        begin
            delta = {24'd0, ({ebyte, el_q} - {sbyte, sl_q})};
        end
        else
        begin
            delta = {32'd0, (el_q - sl_q)};
        end
    end

    assign acc_wdata = acc_cur + delta;
    assign acc_we    = (state_reg == ST_ACC_WR) && src.touched;

    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            acc_mem[n_reg] <= acc_wdata;
        end
        acc_q <= acc_mem[n_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_vld_reg <= '0;
        end
        else if (in_acc && in_clear)
        begin
            acc_vld_reg <= '0;
        end
        else if (acc_we)
        begin
            acc_vld_reg[n_reg] <= 1'b1;
        end
    end

    // per-context check on the pair, using context after clock init
    logic chk_ok, chk_to, chk_from;
    always_comb
    begin
        chk_ok   = 1'b1;
        chk_to   = to_reg;
        chk_from = from_reg;
        if (!fmt_reg && pcm_reg)
        begin
            chk_from = 1'b0;
            if (first_reg == 64'd0 && ctx_reg != s2_reg)
            begin
                if (s2_reg == SWITCH_AWAY)
                begin
                    chk_ok = 1'b0;
                end
                else
                begin
                    chk_to = 1'b1;
                end
            end
            if (chk_ok && s2_reg != e2_reg)
            begin
                if (e2_reg == SWITCH_AWAY)
                begin
                    chk_from = 1'b1;
                end
                else
                begin
                    chk_ok = 1'b0;
                end
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && in_idx == LAST_WORD)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:     state_next = started_reg ? ST_CHECK : ST_MUL;
            ST_MUL:       state_next = ST_DIV;
            ST_DIV:       state_next = ST_DIVW;
            ST_DIVW:
            begin
                if (drsp.done)
                begin
                    unique case (phase_reg)
                        PH_INIT: state_next = ST_CHECK;
                        PH_T1:   state_next = ST_MUL;
                        default: state_next = ST_ACC_RD;
                    endcase
                end
            end
            ST_CHECK:     state_next = chk_ok ? ST_MUL : ST_EMIT_RD;
            ST_ACC_RD:    state_next = ST_ACC_WR;
            ST_ACC_WR:    state_next = (n_reg == LAST_SUM) ? ST_EMIT_RD : ST_ACC_RD;
            ST_EMIT_RD:   state_next = ST_EMIT_LD;
            ST_EMIT_LD:   state_next = ST_EMIT_WAIT;
            ST_EMIT_WAIT:
            begin
                if (m_axis_tready)
                begin
                    state_next = (n_reg == LAST_SUM) ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath register updates
    always_comb
    begin
        phase_next   = phase_reg;
        n_next       = n_reg;
        ok_next      = ok_reg;
        to_next      = to_reg;
        from_next    = from_reg;
        started_next = started_reg;
        clock_next   = clock_reg;
        raw_next     = raw_reg;
        ctx_next     = ctx_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        mul_a_next   = mul_a_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && in_clear)
                begin
                    first_next = 64'd0;
                    last_next  = 64'd0;
                    to_next    = 1'b0;
                    from_next  = 1'b0;
                end
            end
            ST_START:
            begin
                phase_next = PH_INIT;
                mul_a_next = s1_reg;
            end
            ST_DIVW:
            begin
                if (drsp.done)
                begin
                    unique case (phase_reg)
                        PH_INIT:
                        begin
                            clock_next   = q64;
                            raw_next     = s1_reg;
                            started_next = 1'b1;
                            ctx_next     = s2_reg;
                        end
                        PH_T1:
                        begin
                            clock_next = clock_reg + q64;
                            raw_next   = s1_reg;
                            if (first_reg == 64'd0)
                            begin
                                first_next = clock_reg + q64;
                            end
                            phase_next = PH_T2;
                            mul_a_next = e1_reg - s1_reg;
                        end
                        default:
                        begin
                            clock_next = clock_reg + q64;
                            raw_next   = e1_reg;
                            last_next  = clock_reg + q64;
                            n_next     = 6'd0;
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                ok_next    = chk_ok;
                to_next    = chk_to;
                from_next  = chk_from;
                ctx_next   = e2_reg;
                phase_next = PH_T1;
                mul_a_next = s1_reg - raw_reg;
                n_next     = 6'd0;
            end
            ST_ACC_WR:
            begin
                n_next = (n_reg == LAST_SUM) ? 6'd0 : n_reg + 6'd1;
            end
            ST_EMIT_WAIT:
            begin
                if (m_axis_tready)
                begin
                    n_next = n_reg + 6'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_INIT;
            n_reg       <= '0;
            ok_reg      <= 1'b0;
            to_reg      <= 1'b0;
            from_reg    <= 1'b0;
            started_reg <= 1'b0;
            clock_reg   <= '0;
            raw_reg     <= '0;
            ctx_reg     <= '0;
            first_reg   <= '0;
            last_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            n_reg       <= n_next;
            ok_reg      <= ok_next;
            to_reg      <= to_next;
            from_reg    <= from_next;
            started_reg <= started_next;
            clock_reg   <= clock_next;
            raw_reg     <= raw_next;
            ctx_reg     <= ctx_next;
            first_reg   <= first_next;
            last_reg    <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_a_reg <= mul_a_next;
    end

    // output register, loaded from the accumulator read
    logic [OUT_W-1:0] out_reg;
    logic             out_last_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT_LD)
        begin
            out_reg      <= {7'd0, last_reg, first_reg, from_reg, to_reg, ok_reg,
                             acc_cur, n_reg};
            out_last_reg <= (n_reg == LAST_SUM);
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_EMIT_WAIT);
    assign m_axis_tdata  = out_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

FILE: hw/rtl/prda_checker.sv
// prda_checker: port-level assertions for the report delta accumulator
// depends on prda_pkg; bound to perf_report_delta_accumulator

module prda_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic [prda_pkg::IN_W-1:0]  s_axis_tdata,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic [prda_pkg::OUT_W-1:0] m_axis_tdata,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic                       m_axis_tlast
);
    import prda_pkg::*;

    // results only go out while input is held off
    a_busy_when_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while a result is pending");

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed under stall");

    // the final word ends the burst
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not idle after final word");

    // only the final word carries index 61
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[5:0] == LAST_SUM)))
        else $error("tlast does not match index 61");

endmodule

bind perf_report_delta_accumulator prda_checker u_prda_checker (.*);
